// File: hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Opcodes and status codes shared by the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_RESIZE     = 3'd5,
    OP_ASSIGN     = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int unsigned OpW     = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned TargetW = 7;
  localparam int unsigned StatusW = 2;

endpackage

// File: hw/rtl/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/double_ended_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue kept in a circular RAM with head, count and
// direction registers.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Push, pop, reverse and clear pass
// through execute, RAM read and output register load after acceptance, and
// the output register load waits while the output is stalled. Resize and
// assign stay in execute while entries are written or removed one at a time;
// written entries go to both RAMs through one shared write address. A new
// transaction is accepted the cycle after the previous result is loaded into
// the output register, so a finished result may wait there while the next
// one is taken. Front and back values are read from two mirrored RAMs so
// both ends come back in the same read cycle.
module double_ended_queue_core #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [deq_pkg::OpW-1:0]       opcode_i,
  input  logic [deq_pkg::DataW-1:0]     item_value_i,
  input  logic [deq_pkg::TargetW-1:0]   target_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [deq_pkg::DataW-1:0]     front_value_o,
  output logic [deq_pkg::DataW-1:0]     back_value_o,
  output logic [deq_pkg::TargetW-1:0]   entry_count_o,
  output logic                          is_empty_o,
  output logic [deq_pkg::StatusW-1:0]   status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned TW = (CW > deq_pkg::TargetW) ? CW : deq_pkg::TargetW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [AW-1:0]                head_q, head_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         rev_q, rev_d;
  deq_pkg::op_e                 op_q;
  logic [VALUE_WIDTH-1:0]       val_q;
  logic [CW-1:0]                tgt_q;
  logic [deq_pkg::TargetW-1:0]  rem_q, rem_d;
  logic [deq_pkg::StatusW-1:0]  st_q, st_d;

  logic                         out_valid_q;
  logic [deq_pkg::DataW-1:0]    front_q, back_q;
  logic [deq_pkg::TargetW-1:0]  count_out_q;
  logic                         empty_out_q;
  logic [deq_pkg::StatusW-1:0]  status_out_q;

  logic                         in_acc, out_free, tgt_over;
  logic                         full, empty, exec_done;
  logic                         add_front, add_back, drop_front, drop_back;
  logic                         first_add, last_add, first_drop, last_drop;
  logic [AW-1:0]                head_dec, head_inc, tail_slot, last_slot;
  logic [SW-1:0]                tail_sum, last_sum;
  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr;
  logic [VALUE_WIDTH-1:0]       pf_data, pl_data, fv, bv;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tgt_over   = TW'(target_count_i) > TW'(CAPACITY);

  assign full  = (cnt_q == CW'(CAPACITY));
  assign empty = (cnt_q == '0);

  assign head_dec  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
  assign head_inc  = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum  = SW'(head_q) + SW'(cnt_q);
  assign tail_slot = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
                                                 : AW'(tail_sum);
  assign last_sum  = tail_sum - SW'(1);
  assign last_slot = (last_sum >= SW'(CAPACITY)) ? AW'(last_sum - SW'(CAPACITY))
                                                 : AW'(last_sum);

  always_comb begin
    add_front  = 1'b0;
    add_back   = 1'b0;
    drop_front = 1'b0;
    drop_back  = 1'b0;
    exec_done  = 1'b0;
    rev_d      = rev_q;
    rem_d      = rem_q;
    st_d       = st_q;
    cnt_d      = cnt_q;
    if (state_q == S_EXEC) begin
      case (op_q)
        deq_pkg::OP_PUSH_FRONT: begin
          exec_done = 1'b1;
          if (full) st_d = deq_pkg::ST_FULL;
          else add_front = 1'b1;
        end
        deq_pkg::OP_PUSH_BACK: begin
          exec_done = 1'b1;
          if (full) st_d = deq_pkg::ST_FULL;
          else add_back = 1'b1;
        end
        deq_pkg::OP_POP_FRONT: begin
          exec_done = 1'b1;
          if (empty) st_d = deq_pkg::ST_POP_EMPTY;
          else drop_front = 1'b1;
        end
        deq_pkg::OP_POP_BACK: begin
          exec_done = 1'b1;
          if (empty) st_d = deq_pkg::ST_POP_EMPTY;
          else drop_back = 1'b1;
        end
        deq_pkg::OP_REVERSE: begin
          exec_done = 1'b1;
          rev_d     = !rev_q;
        end
        deq_pkg::OP_RESIZE: begin
          if (cnt_q > tgt_q) drop_back = 1'b1;
          else if (cnt_q < tgt_q) add_back = 1'b1;
          else exec_done = 1'b1;
        end
        deq_pkg::OP_ASSIGN: begin
          if (rem_q == '0) begin
            exec_done = 1'b1;
          end else if (full) begin
            exec_done = 1'b1;
            st_d      = deq_pkg::ST_FULL;
          end else begin
            add_front = 1'b1;
            rem_d     = rem_q - 1'b1;
          end
        end
        deq_pkg::OP_CLEAR: begin
          exec_done = 1'b1;
        end
        default: begin
          exec_done = 1'b1;
        end
      endcase
    end

    first_add  = (add_front && !rev_q) || (add_back && rev_q);
    last_add   = (add_back && !rev_q) || (add_front && rev_q);
    first_drop = (drop_front && !rev_q) || (drop_back && rev_q);
    last_drop  = (drop_back && !rev_q) || (drop_front && rev_q);

    head_d = head_q;
    if (first_add) head_d = head_dec;
    else if (first_drop) head_d = head_inc;

    if (first_add || last_add) cnt_d = cnt_q + 1'b1;
    else if (first_drop || last_drop) cnt_d = cnt_q - 1'b1;
    else if ((state_q == S_EXEC) && (op_q == deq_pkg::OP_CLEAR)) cnt_d = '0;

    ram_we    = first_add || last_add;
    ram_waddr = first_add ? head_dec : tail_slot;
    ram_re    = (state_q == S_READ);

    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC:  if (exec_done) state_d = S_READ;
      S_READ:  state_d = S_RESP;
      S_RESP:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  deq_ram #(
    .Width (VALUE_WIDTH),
    .Depth (CAPACITY)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (pf_data)
  );

  deq_ram #(
    .Width (VALUE_WIDTH),
    .Depth (CAPACITY)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (last_slot),
    .rdata_o (pl_data)
  );

  assign fv = empty ? '0 : (rev_q ? pl_data : pf_data);
  assign bv = empty ? '0 : (rev_q ? pf_data : pl_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= deq_pkg::op_e'(opcode_i);
      val_q <= VALUE_WIDTH'(item_value_i);
      tgt_q <= tgt_over ? CW'(CAPACITY) : CW'(target_count_i);
      rem_q <= target_count_i;
      st_q  <= ((deq_pkg::op_e'(opcode_i) == deq_pkg::OP_RESIZE) && tgt_over)
               ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
    end else begin
      rem_q <= rem_d;
      st_q  <= st_d;
    end
    if ((state_q == S_RESP) && out_free) begin
      front_q      <= deq_pkg::DataW'(fv);
      back_q       <= deq_pkg::DataW'(bv);
      count_out_q  <= deq_pkg::TargetW'(cnt_q);
      empty_out_q  <= empty;
      status_out_q <= st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign entry_count_o = count_out_q;
  assign is_empty_o    = empty_out_q;
  assign status_o      = status_out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(CAPACITY - 1))
    else $error("head index out of range");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EXEC))
    else $error("accepted transaction did not enter execute");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("result issued outside response state");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == deq_pkg::ST_POP_EMPTY)) |-> is_empty_o)
    else $error("pop-on-empty status with entries present");
`endif

endmodule
